/* rtl/core/css_pkg.sv */
// Shared types and constants for the chained segment store.
// No dependencies; imported by the top level.
`default_nettype none
package css_pkg;

  // Default sizes
  localparam int DEF_MAX_ENTRIES       = 256;
  localparam int DEF_MAX_SEGMENTS      = 256;
  localparam int DEF_MAX_SEGMENT_WORDS = 16;

  // Command codes on func
  localparam logic [2:0] FN_FORMAT    = 3'd0;
  localparam logic [2:0] FN_CREATE    = 3'd1;
  localparam logic [2:0] FN_WRITE     = 3'd2;
  localparam logic [2:0] FN_READ_OPEN = 3'd3;
  localparam logic [2:0] FN_READ_NEXT = 3'd4;
  localparam logic [2:0] FN_REMOVE    = 3'd5;

  // Status codes
  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_EXISTS       = 3'd1;
  localparam logic [2:0] STS_OUT_OF_TABLE = 3'd2;
  localparam logic [2:0] STS_NO_SPACE     = 3'd3;
  localparam logic [2:0] STS_NOT_FOUND    = 3'd4;
  localparam logic [2:0] STS_CHAIN_ERROR  = 3'd5;
  localparam logic [2:0] STS_SEQUENCE     = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_TABLE_ENTRIES = 2'd0;
  localparam logic [1:0] REG_SEGMENTS      = 2'd1;
  localparam logic [1:0] REG_SEG_WORDS     = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_WR_NEXT, S_RD_DATA, S_RD_NEXT,
    S_ENT_CHK, S_CNT_RD, S_CNT_CHK, S_CNT_MUL, S_CNT_CMP,
    S_ALLOC_RD, S_ALLOC_CHK, S_ALLOC_LNK, S_ALLOC_STEP, S_CREATE_END,
    S_WALK_RD, S_WALK_CHK, S_WALK_OK, S_FREE_RD, S_FREE_CHK, S_REM_END,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/css_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module css_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one address per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/core/chained_segment_store_unit.sv */
// Top level of the chained segment store: sequencer, cursors and counters.
// Depends on css_pkg and css_ram (link, entry and payload memories).
`default_nettype none
// Entries live as chains of segments in a single-port link RAM; one sequencer
// walks it one address at a time, so the input is not ready while a command
// runs. Write word and read_next follow the link when they cross a segment.
// Create counts the free segments over segments_in_use, then scans the link
// RAM to allocate; read_open walks the chain, and remove walks it and then
// frees its segments. Format, a write to configuration index 0 to 2 and reset
// run a clearing pass over max(MAX_ENTRIES, MAX_SEGMENTS) addresses (256 by
// default) before the next word is taken. A finished result waits in the
// output register while the next word is accepted.
module chained_segment_store_unit #(
  parameter int MAX_ENTRIES       = css_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_SEGMENTS      = css_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_SEGMENT_WORDS = css_pkg::DEF_MAX_SEGMENT_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [8:0]  entry_id,
  input  wire logic [15:0] length_bytes,
  input  wire logic [63:0] data_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [63:0]      read_word,
  output logic [3:0]       valid_bytes,
  output logic             last_word,
  output logic [15:0]      entry_length,
  output logic [8:0]       entries_used,
  output logic [8:0]       segments_used,
  output logic [15:0]      bytes_used
);
  import css_pkg::*;

  localparam int SEGW = $clog2(MAX_SEGMENTS + 2);
  localparam int SAW  = $clog2(MAX_SEGMENTS);
  localparam int EAW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PDEPTH = MAX_SEGMENTS * MAX_SEGMENT_WORDS;
  localparam int PAW  = $clog2(PDEPTH);
  localparam int WIW  = (MAX_SEGMENT_WORDS > 1) ? $clog2(MAX_SEGMENT_WORDS) : 1;
  localparam int CLRN = (MAX_ENTRIES > MAX_SEGMENTS) ? MAX_ENTRIES : MAX_SEGMENTS;
  localparam int CW   = $clog2(CLRN);
  localparam logic [CW-1:0]   CLR_LAST = CW'(CLRN - 1);
  localparam logic [SEGW-1:0] LINK_END = '1;

  function automatic logic [8:0] clampv(input logic [8:0] v, input int mx);
    if (v == 9'd0) return 9'd1;
    if (32'(v) > mx) return 9'(mx);
    return v;
  endfunction

  function automatic logic seg_ok(input logic [SEGW-1:0] x);
    return (x != '0) && (32'(x) <= MAX_SEGMENTS);
  endfunction

  state_t state, state_next;

  // Configuration
  logic [8:0] tbl, nsegs, wps;
  logic [11:0] cap;

  // Command word
  logic [2:0]  func_q;
  logic [8:0]  id_q;
  logic [15:0] len_q;
  logic [63:0] data_q;

  // Cursors
  logic            w_act;
  logic [SEGW-1:0] w_seg;
  logic [WIW-1:0]  w_idx;
  logic [13:0]     w_left;
  logic            r_open;
  logic [SEGW-1:0] r_seg;
  logic [WIW-1:0]  r_idx;
  logic [15:0]     r_rem;
  logic [8:0]      r_entry;

  // Counters
  logic [8:0]  ent_cnt, seg_cnt;
  logic [15:0] byte_cnt;

  // Work registers
  logic [CW-1:0]   clr;
  logic            clr_cmd;
  logic [SEGW-1:0] s, prev, first, found, freec, seg, n, steps;
  logic [15:0]     rem, blen;
  logic [31:0]     prod;

  // Result being built
  logic [2:0]  res_status;
  logic [63:0] res_word;
  logic [3:0]  res_vb;
  logic        res_last;
  logic [15:0] res_elen;

  // Memory ports
  logic            lk_we, en_we, pl_we;
  logic [SAW-1:0]  lk_addr;
  logic [SEGW-1:0] lk_wdata, lk_rdata;
  logic [EAW-1:0]  en_addr;
  logic [SEGW-1:0] enf_wdata, enf_rdata;
  logic [15:0]     enb_wdata, enb_rdata;
  logic [PAW-1:0]  pl_addr;
  logic [63:0]     pl_rdata;

  // Decoded conditions
  logic        id_bad, w_wrap, r_wrap, rem_fits;
  logic [3:0]  vb;
  logic [63:0] rmask;
  logic [SAW-1:0] w_sidx, r_sidx;

  assign cap      = {wps, 3'b000};
  assign id_bad   = (id_q == 9'd0) || (id_q > tbl);
  assign w_wrap   = (32'(w_idx) + 1) >= 32'(wps);
  assign r_wrap   = (32'(r_idx) + 1) >= 32'(wps);
  assign rem_fits = rem <= 16'(cap);
  assign vb       = (r_rem < 16'd8) ? r_rem[3:0] : 4'd8;
  assign rmask    = (vb == 4'd8) ? '1 : ((64'd1 << {vb, 3'b000}) - 64'd1);
  assign w_sidx   = SAW'(w_seg - SEGW'(1));
  assign r_sidx   = SAW'(r_seg - SEGW'(1));
  assign in_ready = (state == S_IDLE);

  css_ram #(.WIDTH(SEGW), .DEPTH(MAX_SEGMENTS)) u_link (
    .clk(clk), .we(lk_we), .addr(lk_addr), .wdata(lk_wdata), .rdata(lk_rdata)
  );
  css_ram #(.WIDTH(SEGW), .DEPTH(MAX_ENTRIES)) u_first (
    .clk(clk), .we(en_we), .addr(en_addr), .wdata(enf_wdata), .rdata(enf_rdata)
  );
  css_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_bytes (
    .clk(clk), .we(en_we), .addr(en_addr), .wdata(enb_wdata), .rdata(enb_rdata)
  );
  css_ram #(.WIDTH(64), .DEPTH(PDEPTH)) u_payload (
    .clk(clk), .we(pl_we), .addr(pl_addr), .wdata(data_q), .rdata(pl_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == CLR_LAST) state_next = clr_cmd ? S_DONE : S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (func_q == FN_FORMAT) begin
          state_next = S_CLEAR;
        end else if (func_q == FN_WRITE) begin
          state_next = (w_act && w_left != 14'd1 && w_wrap) ? S_WR_NEXT : S_DONE;
        end else if (w_act || func_q > FN_REMOVE) begin
          state_next = S_DONE;
        end else if (func_q == FN_READ_NEXT) begin
          state_next = r_open ? S_RD_DATA : S_DONE;
        end else begin
          state_next = id_bad ? S_DONE : S_ENT_CHK;
        end
      end
      S_WR_NEXT: state_next = S_DONE;
      S_RD_DATA: state_next = (r_rem > 16'd8 && r_wrap) ? S_RD_NEXT : S_DONE;
      S_RD_NEXT: state_next = S_DONE;
      S_ENT_CHK: begin
        if (func_q == FN_CREATE) begin
          state_next = (enf_rdata != '0 || len_q == 16'd0) ? S_DONE : S_CNT_RD;
        end else begin
          state_next = (enf_rdata == '0) ? S_DONE : S_WALK_RD;
        end
      end
      S_CNT_RD: state_next = (32'(s) > 32'(nsegs)) ? S_CNT_MUL : S_CNT_CHK;
      S_CNT_CHK: state_next = S_CNT_RD;
      S_CNT_MUL: state_next = S_CNT_CMP;
      S_CNT_CMP: state_next = (prod < 32'(len_q)) ? S_DONE : S_ALLOC_RD;
      S_ALLOC_RD: state_next = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (lk_rdata != '0) state_next = S_ALLOC_RD;
        else state_next = (prev != '0) ? S_ALLOC_LNK : S_ALLOC_STEP;
      end
      S_ALLOC_LNK: state_next = S_ALLOC_STEP;
      S_ALLOC_STEP: state_next = rem_fits ? S_CREATE_END : S_ALLOC_RD;
      S_CREATE_END: state_next = S_DONE;
      S_WALK_RD: begin
        state_next = (!seg_ok(seg) || 32'(steps) >= MAX_SEGMENTS) ? S_DONE : S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (lk_rdata == '0) state_next = S_DONE;
        else if (rem_fits) state_next = (lk_rdata == LINK_END) ? S_WALK_OK : S_DONE;
        else if (!seg_ok(lk_rdata)) state_next = S_DONE;
        else state_next = S_WALK_RD;
      end
      S_WALK_OK: state_next = (func_q == FN_READ_OPEN) ? S_DONE : S_FREE_RD;
      S_FREE_RD: state_next = (steps >= n || !seg_ok(seg)) ? S_REM_END : S_FREE_CHK;
      S_FREE_CHK: state_next = S_FREE_RD;
      S_REM_END: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cfg_we && cfg_index <= REG_SEG_WORDS) state_next = S_CLEAR;
  end

  // Memory controls
  always_comb begin
    lk_we     = 1'b0;
    lk_addr   = SAW'(seg - SEGW'(1));
    lk_wdata  = '0;
    en_we     = 1'b0;
    en_addr   = EAW'(id_q - 9'd1);
    enf_wdata = '0;
    enb_wdata = '0;
    pl_we     = 1'b0;
    if (state == S_DECODE && func_q == FN_WRITE) begin
      pl_addr = PAW'(32'(w_sidx) * MAX_SEGMENT_WORDS + 32'(w_idx));
    end else begin
      pl_addr = PAW'(32'(r_sidx) * MAX_SEGMENT_WORDS + 32'(r_idx));
    end
    case (state)
      S_CLEAR: begin
        lk_addr = SAW'(clr);
        en_addr = EAW'(clr);
        lk_we   = 32'(clr) < MAX_SEGMENTS;
        en_we   = 32'(clr) < MAX_ENTRIES;
      end
      S_DECODE: begin
        lk_addr = w_sidx;
        pl_we   = (func_q == FN_WRITE) && w_act;
      end
      S_RD_DATA: lk_addr = r_sidx;
      S_CNT_RD, S_ALLOC_RD: lk_addr = SAW'(s - SEGW'(1));
      S_ALLOC_CHK: begin
        lk_addr  = SAW'(s - SEGW'(1));
        lk_we    = (lk_rdata == '0);
        lk_wdata = LINK_END;
      end
      S_ALLOC_LNK: begin
        lk_addr  = SAW'(prev - SEGW'(1));
        lk_we    = 1'b1;
        lk_wdata = s;
      end
      S_FREE_CHK: lk_we = 1'b1;
      S_CREATE_END: begin
        en_we     = 1'b1;
        enf_wdata = first;
        enb_wdata = len_q;
      end
      S_REM_END: en_we = 1'b1;
      default: ;
    endcase
  end

  // Sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      clr_cmd  <= 1'b0;
      tbl      <= clampv(9'(DEF_MAX_ENTRIES), MAX_ENTRIES);
      nsegs    <= clampv(9'(DEF_MAX_SEGMENTS), MAX_SEGMENTS);
      wps      <= clampv(9'(MAX_SEGMENT_WORDS), MAX_SEGMENT_WORDS);
      w_act    <= 1'b0;
      r_open   <= 1'b0;
      ent_cnt  <= '0;
      seg_cnt  <= '0;
      byte_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr <= clr + CW'(1);
        S_IDLE: if (in_valid) begin
          func_q     <= func;
          id_q       <= entry_id;
          len_q      <= length_bytes;
          data_q     <= data_word;
          res_status <= STS_OK;
          res_word   <= '0;
          res_vb     <= '0;
          res_last   <= 1'b0;
          res_elen   <= '0;
        end
        S_DECODE: begin
          if (func_q == FN_FORMAT) begin
            ent_cnt  <= '0;
            seg_cnt  <= '0;
            byte_cnt <= '0;
            w_act    <= 1'b0;
            r_open   <= 1'b0;
            clr      <= '0;
            clr_cmd  <= 1'b1;
          end else if (func_q == FN_WRITE) begin
            if (!w_act) begin
              res_status <= STS_SEQUENCE;
            end else begin
              w_left <= w_left - 14'd1;
              if (w_left == 14'd1) w_act <= 1'b0;
              else if (w_wrap) w_idx <= '0;
              else w_idx <= w_idx + WIW'(1);
            end
          end else if (w_act || func_q > FN_REMOVE) begin
            res_status <= STS_SEQUENCE;
          end else if (func_q == FN_READ_NEXT) begin
            if (!r_open) res_status <= STS_SEQUENCE;
          end else if (id_bad) begin
            res_status <= STS_OUT_OF_TABLE;
          end
        end
        S_WR_NEXT: w_seg <= lk_rdata;
        S_RD_DATA: begin
          res_word <= pl_rdata & rmask;
          res_vb   <= vb;
          r_rem    <= r_rem - 16'(vb);
          if (r_rem <= 16'd8) begin
            res_last <= 1'b1;
            r_open   <= 1'b0;
          end else if (r_wrap) begin
            r_idx <= '0;
          end else begin
            r_idx <= r_idx + WIW'(1);
          end
        end
        S_RD_NEXT: r_seg <= lk_rdata;
        S_ENT_CHK: begin
          first <= enf_rdata;
          blen  <= enb_rdata;
          seg   <= enf_rdata;
          s     <= SEGW'(1);
          freec <= '0;
          n     <= '0;
          steps <= '0;
          if (func_q == FN_CREATE) begin
            rem <= len_q;
            if (enf_rdata != '0) res_status <= STS_EXISTS;
            else if (len_q == 16'd0) res_status <= STS_NO_SPACE;
          end else begin
            rem <= enb_rdata;
            if (enf_rdata == '0) res_status <= STS_NOT_FOUND;
          end
        end
        S_CNT_CHK: begin
          if (lk_rdata == '0) freec <= freec + SEGW'(1);
          s <= s + SEGW'(1);
        end
        S_CNT_MUL: prod <= 32'(freec) * 32'(cap);
        S_CNT_CMP: begin
          if (prod < 32'(len_q)) res_status <= STS_NO_SPACE;
          s     <= SEGW'(1);
          prev  <= '0;
          found <= '0;
        end
        S_ALLOC_CHK: begin
          if (lk_rdata != '0) begin
            s <= s + SEGW'(1);
          end else begin
            found <= found + SEGW'(1);
            if (prev == '0) first <= s;
          end
        end
        S_ALLOC_STEP: begin
          prev <= s;
          if (!rem_fits) begin
            rem <= rem - 16'(cap);
            s   <= s + SEGW'(1);
          end
        end
        S_CREATE_END: begin
          ent_cnt  <= ent_cnt + 9'd1;
          seg_cnt  <= seg_cnt + 9'(found);
          byte_cnt <= byte_cnt + len_q;
          w_act    <= 1'b1;
          w_seg    <= first;
          w_idx    <= '0;
          w_left   <= 14'((17'(len_q) + 17'd7) >> 3);
        end
        S_WALK_RD: begin
          if (!seg_ok(seg) || 32'(steps) >= MAX_SEGMENTS) res_status <= STS_CHAIN_ERROR;
        end
        S_WALK_CHK: begin
          n     <= n + SEGW'(1);
          steps <= steps + SEGW'(1);
          if (lk_rdata == '0) begin
            res_status <= STS_CHAIN_ERROR;
          end else if (rem_fits) begin
            if (lk_rdata != LINK_END) res_status <= STS_CHAIN_ERROR;
          end else if (!seg_ok(lk_rdata)) begin
            res_status <= STS_CHAIN_ERROR;
          end else begin
            rem <= rem - 16'(cap);
            seg <= lk_rdata;
          end
        end
        S_WALK_OK: begin
          if (func_q == FN_READ_OPEN) begin
            res_elen <= blen;
            r_open   <= 1'b1;
            r_seg    <= first;
            r_idx    <= '0;
            r_rem    <= blen;
            r_entry  <= id_q;
          end else begin
            seg   <= first;
            steps <= '0;
          end
        end
        S_FREE_CHK: begin
          seg   <= lk_rdata;
          steps <= steps + SEGW'(1);
        end
        S_REM_END: begin
          ent_cnt  <= ent_cnt - 9'd1;
          seg_cnt  <= seg_cnt - 9'(n);
          byte_cnt <= byte_cnt - blen;
          if (r_open && r_entry == id_q) r_open <= 1'b0;
        end
        default: ;
      endcase

      // Drop a taken result; load the new one when the slot is free
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid     <= 1'b1;
        status        <= res_status;
        read_word     <= res_word;
        valid_bytes   <= res_vb;
        last_word     <= res_last;
        entry_length  <= res_elen;
        entries_used  <= ent_cnt;
        segments_used <= seg_cnt;
        bytes_used    <= byte_cnt;
      end

      // A register write to index 0 to 2 reformats the store
      if (cfg_we) begin
        case (cfg_index)
          REG_TABLE_ENTRIES: tbl <= clampv(cfg_data, MAX_ENTRIES);
          REG_SEGMENTS:      nsegs <= clampv(cfg_data, MAX_SEGMENTS);
          REG_SEG_WORDS:     wps <= clampv(cfg_data, MAX_SEGMENT_WORDS);
          default: ;
        endcase
        if (cfg_index <= REG_SEG_WORDS) begin
          ent_cnt  <= '0;
          seg_cnt  <= '0;
          byte_cnt <= '0;
          w_act    <= 1'b0;
          r_open   <= 1'b0;
          clr      <= '0;
          clr_cmd  <= 1'b0;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    seg_cnt <= nsegs) else $error("allocated segments exceed segments in use");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    ent_cnt == 9'd0 |-> seg_cnt == 9'd0 && byte_cnt == 16'd0)
    else $error("counters disagree with empty store");
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !cfg_we |=> state == S_DECODE)
    else $error("accepted word not decoded");
  a_wcur: assert property (@(posedge clk) disable iff (rst)
    w_act |-> w_seg != '0 && w_left != 14'd0)
    else $error("pending write with empty cursor");
`endif

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for chained_segment_store_unit: valid/ready stimulus,
// an internal predictor of the store and a check of every result field.
// Depends on css_pkg and the RTL of the chained segment store.
module testbench;
  import css_pkg::*;

  localparam int N_ENT   = DEF_MAX_ENTRIES;
  localparam int N_SEG   = DEF_MAX_SEGMENTS;
  localparam int N_WORDS = DEF_MAX_SEGMENT_WORDS;
  localparam int CHAIN_END = 'hFFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [8:0]  id;
    logic [15:0] len;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] rword;
    logic [3:0]  vbytes;
    logic        last;
    logic [15:0] elen;
    logic [8:0]  n_ent;
    logic [8:0]  n_seg;
    logic [15:0] n_bytes;
  } reply_t;

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [2:0]  func, status;
  logic [8:0]  entry_id, entries_used, segments_used;
  logic [15:0] length_bytes, entry_length, bytes_used;
  logic [63:0] data_word, read_word;
  logic [3:0]  valid_bytes;
  logic        last_word;

  chained_segment_store_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .entry_id(entry_id),
    .length_bytes(length_bytes), .data_word(data_word), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .read_word(read_word),
    .valid_bytes(valid_bytes), .last_word(last_word), .entry_length(entry_length),
    .entries_used(entries_used), .segments_used(segments_used), .bytes_used(bytes_used)
  );

  cmd_t   pending_cmds[$];
  reply_t expected_replies[$];
  int     mismatches;
  bit     in_taken;

  // Store shadow
  int          tbl_lim, seg_lim, seg_words;
  logic [63:0] shadow_payload[N_SEG * N_WORDS];
  int          seg_next[N_SEG];
  int          ent_first[N_ENT];
  int          ent_len[N_ENT];
  int          ent_total, seg_total, byte_total;
  bit          wr_busy;
  int          wr_seg, wr_idx, wr_left;
  bit          rd_open;
  int          rd_seg, rd_idx, rd_rem, rd_ent;

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < N_SEG; i++) seg_next[i] = 0;
    for (int i = 0; i < N_ENT; i++) begin
      ent_first[i] = 0;
      ent_len[i] = 0;
    end
    ent_total = 0; seg_total = 0; byte_total = 0;
    wr_busy = 0; wr_seg = 0; wr_idx = 0; wr_left = 0;
    rd_open = 0; rd_seg = 0; rd_idx = 0; rd_rem = 0; rd_ent = 0;
  endfunction

  // Walk a chain for len bytes; report soundness and segment count
  function automatic bit chain_sound(int first, int len, output int nseg);
    int s, rem, lk;
    s = first; rem = len; nseg = 0;
    for (int step = 0; step < N_SEG; step++) begin
      if (s < 1 || s > N_SEG) return 0;
      lk = seg_next[s-1];
      nseg++;
      if (lk == 0) return 0;
      if (rem <= 8 * seg_words) return lk == CHAIN_END;
      if (lk == CHAIN_END || lk > N_SEG) return 0;
      rem -= 8 * seg_words;
      s = lk;
    end
    return 0;
  endfunction

  function automatic reply_t store_step(cmd_t c);
    reply_t r;
    int id, cap, need, freec, prev, found, first, n, s, nx, vb;
    logic [63:0] w;
    r = '0;
    id = c.id;
    cap = 8 * seg_words;
    r.status = STS_OK;
    if (c.func == FN_FORMAT) begin
      wipe_store();
    end else if (c.func == FN_WRITE) begin
      if (!wr_busy) r.status = STS_SEQUENCE;
      else begin
        s = wr_seg;
        if (s >= 1 && s <= N_SEG && wr_idx < N_WORDS)
          shadow_payload[(s-1)*N_WORDS + wr_idx] = c.data;
        wr_left--;
        if (wr_left == 0) wr_busy = 0;
        else if (++wr_idx >= seg_words) begin
          wr_idx = 0;
          wr_seg = (s >= 1 && s <= N_SEG) ? seg_next[s-1] : 0;
        end
      end
    end else if (wr_busy || c.func > FN_REMOVE) begin
      r.status = STS_SEQUENCE;
    end else if (c.func == FN_READ_NEXT) begin
      if (!rd_open) r.status = STS_SEQUENCE;
      else begin
        s = rd_seg;
        w = '0;
        if (s >= 1 && s <= N_SEG && rd_idx < N_WORDS)
          w = shadow_payload[(s-1)*N_WORDS + rd_idx];
        vb = rd_rem < 8 ? rd_rem : 8;
        if (vb < 8) w &= (64'd1 << (8 * vb)) - 64'd1;
        r.rword = w;
        r.vbytes = 4'(vb);
        rd_rem -= vb;
        if (rd_rem == 0) begin
          r.last = 1'b1;
          rd_open = 0;
        end else if (++rd_idx >= seg_words) begin
          rd_idx = 0;
          rd_seg = (s >= 1 && s <= N_SEG) ? seg_next[s-1] : 0;
        end
      end
    end else if (id == 0 || id > tbl_lim) begin
      r.status = STS_OUT_OF_TABLE;
    end else if (c.func == FN_CREATE) begin
      if (ent_first[id-1] != 0) r.status = STS_EXISTS;
      else if (c.len == 0) r.status = STS_NO_SPACE;
      else begin
        need = (int'(c.len) + cap - 1) / cap;
        freec = 0;
        for (int i = 0; i < seg_lim; i++) if (seg_next[i] == 0) freec++;
        if (freec < need) r.status = STS_NO_SPACE;
        else begin
          prev = 0; found = 0; first = 0;
          for (int i = 1; i <= seg_lim && found < need; i++) begin
            if (seg_next[i-1] == 0) begin
              if (prev != 0) seg_next[prev-1] = i;
              else first = i;
              seg_next[i-1] = CHAIN_END;
              prev = i;
              found++;
            end
          end
          ent_first[id-1] = first;
          ent_len[id-1] = c.len;
          ent_total++;
          seg_total += need;
          byte_total += c.len;
          wr_busy = 1; wr_seg = first; wr_idx = 0; wr_left = (int'(c.len) + 7) / 8;
        end
      end
    end else begin
      first = ent_first[id-1];
      if (first == 0) r.status = STS_NOT_FOUND;
      else if (!chain_sound(first, ent_len[id-1], n)) r.status = STS_CHAIN_ERROR;
      else if (c.func == FN_READ_OPEN) begin
        r.elen = 16'(ent_len[id-1]);
        rd_open = 1; rd_seg = first; rd_idx = 0; rd_rem = ent_len[id-1]; rd_ent = id;
      end else begin
        s = first;
        for (int k = 0; k < n && s >= 1 && s <= N_SEG; k++) begin
          nx = seg_next[s-1];
          seg_next[s-1] = 0;
          s = nx;
        end
        ent_total--;
        seg_total -= n;
        byte_total -= ent_len[id-1];
        ent_first[id-1] = 0;
        ent_len[id-1] = 0;
        if (rd_open && rd_ent == id) rd_open = 0;
      end
    end
    r.n_ent = 9'(ent_total);
    r.n_seg = 9'(seg_total);
    r.n_bytes = 16'(byte_total);
    return r;
  endfunction

  // Clock and reset
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 0;
  end

  // Record accepted words and check results
  always @(posedge clk) begin
    reply_t got, exp;
    in_taken = !rst && in_valid && in_ready;
    if (in_taken)
      expected_replies.push_back(store_step({func, entry_id, length_bytes, data_word}));
    if (!rst && out_valid && out_ready) begin
      got = {status, read_word, valid_bytes, last_word, entry_length,
             entries_used, segments_used, bytes_used};
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp = expected_replies.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sts=%0d w=%h vb=%0d l=%0d len=%0d e=%0d s=%0d b=%0d",
                     exp.status, exp.rword, exp.vbytes, exp.last, exp.elen, exp.n_ent,
                     exp.n_seg, exp.n_bytes,
                     " / got sts=%0d w=%h vb=%0d l=%0d len=%0d e=%0d s=%0d b=%0d",
                     got.status, got.rword, got.vbytes, got.last, got.elen,
                     got.n_ent, got.n_seg, got.n_bytes);
        end
      end
    end
  end

  // Pick a gap: mostly none or short, a few long; quiet stretches have none
  int quiet_cnt;
  bit quiet;
  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver and receiver, changing at the falling edge
  int in_gap, out_gap;
  always @(negedge clk) begin
    if (quiet_cnt == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      quiet_cnt = $urandom_range(20, 150);
    end else quiet_cnt--;
    if (!rst && (!in_valid || in_taken)) begin
      if (in_gap > 0 || pending_cmds.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 0;
      end else begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_valid <= 1;
        func <= c.func; entry_id <= c.id; length_bytes <= c.len; data_word <= c.data;
        in_gap = pick_gap();
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      out_gap = pick_gap();
    end
  end

  // Generator view of the store
  int gen_len[N_ENT + 1];
  int gen_tbl, gen_cap;

  function automatic void push_cmd(logic [2:0] f, int id, int len, logic [63:0] d);
    cmd_t c;
    c.func = f; c.id = 9'(id); c.len = 16'(len); c.data = d;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_id();
    int p;
    p = $urandom_range(0, 99);
    if (p < 90) return $urandom_range(1, gen_tbl);
    if (p < 94) return 0;
    if (p < 97) return (gen_tbl < 511) ? gen_tbl + 1 : 511;
    return $urandom_range(0, 511);
  endfunction

  task automatic settle();
    wait (!rst);
    while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register while idle; every write also formats the store
  task automatic set_reg(logic [1:0] idx, int v);
    settle();
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= 9'(v);
    case (idx)
      REG_TABLE_ENTRIES: tbl_lim = clamp_to(v, N_ENT);
      REG_SEGMENTS:      seg_lim = clamp_to(v, N_SEG);
      default:           seg_words = clamp_to(v, N_WORDS);
    endcase
    wipe_store();
    @(negedge clk);
    cfg_we <= 0;
    gen_tbl = tbl_lim;
    gen_cap = 8 * seg_words;
    for (int i = 0; i <= N_ENT; i++) gen_len[i] = 0;
  endtask

  task automatic random_phase(int n_items);
    int cnt, p, id, len, nw, k;
    cnt = 0;
    while (cnt < n_items) begin
      p = $urandom_range(0, 99);
      id = pick_id();
      if (p < 32) begin
        // create and fill, sometimes cut short
        k = $urandom_range(0, 99);
        if (k < 3) len = 0;
        else if (k < 5) len = $urandom_range(0, 65535);
        else if (k < 8) len = $urandom_range(1, gen_cap * 8);
        else len = $urandom_range(1, gen_cap * 3);
        push_cmd(FN_CREATE, id, len, rnd64());
        cnt++;
        if (id >= 1 && id <= gen_tbl && gen_len[id] == 0 && len > 0 && len <= 32768) begin
          nw = (len + 7) / 8;
          if ($urandom_range(0, 9) == 0) nw = $urandom_range(0, nw);
          for (int i = 0; i < nw; i++) push_cmd(FN_WRITE, 0, 0, rnd64());
          cnt += nw;
          gen_len[id] = len;
        end
      end else if (p < 62) begin
        // open and read through, sometimes past the end
        push_cmd(FN_READ_OPEN, id, $urandom_range(0, 65535), rnd64());
        k = (id <= N_ENT && gen_len[id] != 0) ? (gen_len[id] + 7) / 8 : $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) k = k + 1;
        else if ($urandom_range(0, 9) == 0) k = $urandom_range(0, k);
        for (int i = 0; i < k; i++) push_cmd(FN_READ_NEXT, id, 0, rnd64());
        cnt += 1 + k;
      end else if (p < 82) begin
        push_cmd(FN_REMOVE, id, 0, rnd64());
        if (id <= N_ENT) gen_len[id] = 0;
        cnt++;
      end else if (p < 87) begin
        push_cmd(FN_WRITE, id, $urandom_range(0, 65535), rnd64());
        cnt++;
      end else if (p < 91) begin
        push_cmd(3'($urandom_range(6, 7)), id, $urandom_range(0, 65535), rnd64());
        cnt++;
      end else if (p < 93) begin
        push_cmd(FN_FORMAT, id, 0, rnd64());
        for (int i = 0; i <= N_ENT; i++) gen_len[i] = 0;
        cnt++;
      end else begin
        push_cmd(FN_READ_NEXT, id, 0, rnd64());
        cnt++;
      end
    end
  endtask

  // Stimulus: directed checks, then random phases over several layouts
  initial begin
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; out_ready = 0; in_taken = 0;
    func = 0; entry_id = 0; length_bytes = 0; data_word = 0;
    mismatches = 0; in_gap = 0; out_gap = 0; quiet = 0; quiet_cnt = 0;
    for (int i = 0; i < N_SEG * N_WORDS; i++) shadow_payload[i] = '0;
    tbl_lim = N_ENT; seg_lim = N_SEG; seg_words = N_WORDS;
    wipe_store();
    gen_tbl = N_ENT; gen_cap = 8 * N_WORDS;
    for (int i = 0; i <= N_ENT; i++) gen_len[i] = 0;

    // directed
    push_cmd(FN_CREATE, 256, 1, '0);
    push_cmd(FN_WRITE, 0, 0, '1);
    push_cmd(FN_CREATE, 1, 0, '0);
    push_cmd(FN_CREATE, 0, 8, '0);
    push_cmd(FN_CREATE, 257, 8, '0);
    push_cmd(FN_CREATE, 1, 9, '0);
    push_cmd(FN_WRITE, 0, 0, 64'h0123456789ABCDEF);
    push_cmd(FN_READ_OPEN, 1, 0, '0);
    push_cmd(FN_WRITE, 0, 16'hFFFF, '1);
    push_cmd(FN_CREATE, 1, 9, '0);
    push_cmd(FN_READ_OPEN, 1, 0, '0);
    push_cmd(FN_READ_NEXT, 0, 0, '0);
    push_cmd(FN_READ_NEXT, 0, 0, '0);
    push_cmd(FN_READ_NEXT, 0, 0, '0);
    push_cmd(FN_READ_OPEN, 5, 0, '0);
    push_cmd(FN_REMOVE, 1, 0, '0);
    push_cmd(FN_REMOVE, 1, 0, '0);
    push_cmd(3'd7, 511, 16'hFFFF, '1);
    push_cmd(FN_WRITE, 0, 0, '0);
    push_cmd(FN_CREATE, 2, 16'hFFFF, '0);
    push_cmd(FN_READ_OPEN, 256, 0, '0);
    push_cmd(FN_REMOVE, 256, 0, '0);
    push_cmd(FN_READ_NEXT, 0, 0, '0);
    push_cmd(FN_FORMAT, 0, 0, '0);
    random_phase(130);

    set_reg(REG_TABLE_ENTRIES, 0);
    set_reg(REG_SEGMENTS, 0);
    set_reg(REG_SEG_WORDS, 0);
    random_phase(70);

    set_reg(REG_TABLE_ENTRIES, 8);
    set_reg(REG_SEGMENTS, 12);
    set_reg(REG_SEG_WORDS, 2);
    random_phase(180);

    set_reg(REG_TABLE_ENTRIES, 20);
    set_reg(REG_SEGMENTS, 40);
    set_reg(REG_SEG_WORDS, 5);
    random_phase(140);

    set_reg(REG_TABLE_ENTRIES, 511);
    set_reg(REG_SEGMENTS, 300);
    set_reg(REG_SEG_WORDS, 31);
    random_phase(150);

    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
